// ===== sv/paged_first_fit_allocator_assert.svh =====
// ----------------------------------------------------------------------------
// Paged first-fit allocator assertion macros
// Shared property forms for the allocator's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef PAGED_FIRST_FIT_ALLOCATOR_ASSERT_SVH
`define PAGED_FIRST_FIT_ALLOCATOR_ASSERT_SVH

// Condition holds at every clock edge outside reset.
`define PFF_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Trigger implies the consequence in the next cycle.
`define PFF_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/pff_pkg.sv =====
// ----------------------------------------------------------------------------
// Paged first-fit allocator package
// Shared widths, page geometry, status codes and interface types.
// ----------------------------------------------------------------------------
package pff_pkg;

  localparam int PAGE_BYTES   = 4096;
  localparam int PAGE_SHIFT   = $clog2(PAGE_BYTES);
  localparam int PAGE_LIMIT   = 8;
  localparam int TABLE_DEPTH  = 64;
  localparam int ADDR_W       = 15;
  localparam int PAGE_W       = ADDR_W - PAGE_SHIFT;
  localparam int LEN_W        = 12;
  localparam int SIZE_W       = 16;
  localparam int BUMP_W       = 16;
  localparam int PAGES_W      = 4;
  localparam int STATUS_W     = 3;

  localparam logic [PAGES_W-1:0] MAX_PAGES_RST = 4'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_MEM    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_FREE  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Table update strobes from the sequencer
  typedef struct packed {
    logic wr;
    logic clr;
  } tbl_cmd_t;

endpackage

// ===== sv/pff_table.sv =====
// ----------------------------------------------------------------------------
// Paged first-fit allocator block table
// Start and length memories with one registered read port, plus live bits.
// ----------------------------------------------------------------------------
module pff_table import pff_pkg::*; #(
  parameter int Depth = TABLE_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [$clog2(Depth)-1:0] rd_idx_i,
  output logic [ADDR_W-1:0]        rd_start_o,
  output logic [LEN_W-1:0]         rd_len_o,
  output logic                     rd_live_o,
  input  tbl_cmd_t                 cmd_i,
  input  logic [$clog2(Depth)-1:0] wr_idx_i,
  input  logic [ADDR_W-1:0]        wr_start_i,
  input  logic [LEN_W-1:0]         wr_len_i
);

  logic [ADDR_W-1:0] start_mem [Depth];
  logic [LEN_W-1:0]  len_mem   [Depth];
  logic [Depth-1:0]  live_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      start_mem[wr_idx_i] <= wr_start_i;
      len_mem[wr_idx_i]   <= wr_len_i;
    end
    rd_start_o <= start_mem[rd_idx_i];
    rd_len_o   <= len_mem[rd_idx_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q    <= '0;
      rd_live_o <= 1'b0;
    end else begin
      rd_live_o <= live_q[rd_idx_i];
      if (cmd_i.wr) begin
        live_q[wr_idx_i] <= 1'b1;
      end else if (cmd_i.clr) begin
        live_q[wr_idx_i] <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/paged_first_fit_allocator.sv =====
// ----------------------------------------------------------------------------
// Paged first-fit allocator
// Sequencer that serves allocate and free requests over a block table.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel (tuser = opcode, 0 allocate, 1 free);
//   each request gives exactly one result on m_axis. max_pages is set through
//   cfg_wr_en_i / cfg_wr_data_i; the user must write it only while the block
//   is idle, as the block does not enforce this. One request is in flight at
//   a time: s_axis_tready is high only in idle. The table scan reads one
//   entry per cycle through the table's registered read port over all
//   TableDepth entries, then takes its closing step.
//   Free: one scan, then the result.
//   Allocate: one scan per block visited and per page exhausted, then one
//   slot scan, with a bump step before it when it falls back to the bump
//   pointer.
//   Oversized requests give their result in the cycle after the transfer.
//   The result holds on m_axis until taken; a stall on m_axis_tready keeps
//   the block busy and s_axis_tready low. Ready returns in the cycle after
//   the result transfer.
//   Reset clears all live bits, opens one page, sets the bump position to 0
//   and max_pages to 3.
// ----------------------------------------------------------------------------
module paged_first_fit_allocator import pff_pkg::*; #(
  parameter int TableDepth = TABLE_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [15:0] request_size, [30:16] free_address, [31] zero
  input  logic [31:0]  s_axis_tdata,
  // [0] opcode
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [14:0] block_address, [17:15] status, [33:18] bytes_used,
  // [49:34] capacity_bytes, [55:50] zero
  output logic [55:0]  m_axis_tdata,
  input  logic         cfg_wr_en_i,
  input  logic [3:0]   cfg_wr_data_i
);

  localparam int IW = $clog2(TableDepth);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_FREE_SCAN = 4'd1;
  localparam logic [3:0] S_FREE_END  = 4'd2;
  localparam logic [3:0] S_NEXT_SCAN = 4'd3;
  localparam logic [3:0] S_NEXT_END  = 4'd4;
  localparam logic [3:0] S_BUMP      = 4'd5;
  localparam logic [3:0] S_SLOT_SCAN = 4'd6;
  localparam logic [3:0] S_SLOT_END  = 4'd7;
  localparam logic [3:0] S_OUT       = 4'd8;

  logic [3:0]          state_q, state_d;
  logic [PAGES_W-1:0]  max_pages_q;
  logic [PAGES_W-1:0]  pages_open_q, pages_open_d;
  logic [BUMP_W-1:0]   bump_q, bump_d;
  logic [PAGES_W-1:0]  new_pages_q, new_pages_d;
  logic [BUMP_W-1:0]   new_bump_q, new_bump_d;

  logic                op_q, op_d;
  logic [SIZE_W-1:0]   size_q, size_d;
  logic [ADDR_W-1:0]   faddr_q, faddr_d;
  logic [ADDR_W-1:0]   addr_q, addr_d;
  logic [STATUS_W-1:0] status_q, status_d;

  // scan issue and compare stage
  logic                run_q, run_d;
  logic [IW-1:0]       idx_q, idx_d;
  logic                pv_q, pv_d;
  logic                plast_q, plast_d;
  logic [IW-1:0]       pidx_q, pidx_d;

  // scan accumulators
  logic                hit_q, hit_d;
  logic [IW-1:0]       hit_idx_q, hit_idx_d;
  logic                best_q, best_d;
  logic [ADDR_W-1:0]   best_start_q, best_start_d;
  logic [LEN_W-1:0]    best_len_q, best_len_d;
  logic [PAGE_W-1:0]   page_q, page_d;
  logic [LEN_W:0]      last_q, last_d;
  logic [ADDR_W-1:0]   prev_q, prev_d;
  logic                after_q, after_d;

  logic [ADDR_W-1:0]   rd_start;
  logic [LEN_W-1:0]    rd_len;
  logic                rd_live;
  tbl_cmd_t            cmd;
  logic [IW-1:0]       wr_idx;

  logic                s_fire, m_fire, scan_done;
  logic [LEN_W:0]      off_ext, size_ext, gap;
  logic [BUMP_W:0]     bump_sum;
  logic [BUMP_W-1:0]   end_pos, nb;
  logic [PAGES_W-1:0]  limit;

  assign s_fire    = s_axis_tvalid & s_axis_tready;
  assign m_fire    = m_axis_tvalid & m_axis_tready;
  assign scan_done = pv_q & plast_q;

  assign off_ext  = {1'b0, best_start_q[PAGE_SHIFT-1:0]};
  assign size_ext = {1'b0, size_q[LEN_W-1:0]};
  assign gap      = off_ext - last_q;
  assign end_pos  = {pages_open_q, {PAGE_SHIFT{1'b0}}};
  assign bump_sum = {1'b0, bump_q} + {{(BUMP_W+1-LEN_W){1'b0}}, size_q[LEN_W-1:0]};
  assign limit    = (max_pages_q > PAGES_W'(PAGE_LIMIT)) ? PAGES_W'(PAGE_LIMIT)
                                                         : max_pages_q;

  pff_table #(.Depth(TableDepth)) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_idx_i   (idx_q),
    .rd_start_o (rd_start),
    .rd_len_o   (rd_len),
    .rd_live_o  (rd_live),
    .cmd_i      (cmd),
    .wr_idx_i   (wr_idx),
    .wr_start_i (addr_q),
    .wr_len_i   (size_q[LEN_W-1:0])
  );

  always_comb begin
    state_d      = state_q;
    pages_open_d = pages_open_q;
    bump_d       = bump_q;
    new_pages_d  = new_pages_q;
    new_bump_d   = new_bump_q;
    op_d         = op_q;
    size_d       = size_q;
    faddr_d      = faddr_q;
    addr_d       = addr_q;
    status_d     = status_q;
    run_d        = run_q;
    idx_d        = idx_q;
    pv_d         = run_q;
    plast_d      = idx_q == IW'(TableDepth - 1);
    pidx_d       = idx_q;
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    best_d       = best_q;
    best_start_d = best_start_q;
    best_len_d   = best_len_q;
    page_d       = page_q;
    last_d       = last_q;
    prev_d       = prev_q;
    after_d      = after_q;
    cmd          = '0;
    wr_idx       = hit_idx_q;
    nb           = '0;

    // advance the read pointer while a scan runs
    if (run_q) begin
      if (idx_q == IW'(TableDepth - 1)) begin
        run_d = 1'b0;
        idx_d = '0;
      end else begin
        idx_d = idx_q + IW'(1);
      end
    end

    // per-entry compare on the data read in the previous cycle
    if (pv_q && rd_live) begin
      case (state_q)
        S_FREE_SCAN: begin
          if (!hit_q && rd_start == faddr_q) begin
            hit_d     = 1'b1;
            hit_idx_d = pidx_q;
          end
        end
        S_NEXT_SCAN: begin
          if (rd_start[ADDR_W-1:PAGE_SHIFT] == page_q &&
              (!after_q || rd_start > prev_q) &&
              (!best_q || rd_start < best_start_q)) begin
            best_d       = 1'b1;
            best_start_d = rd_start;
            best_len_d   = rd_len;
          end
        end
        S_SLOT_SCAN: begin
          if (rd_start == addr_q) begin
            best_d = 1'b1;
          end
        end
        default: ;
      endcase
    end
    // first free slot in the slot scan
    if (pv_q && !rd_live && state_q == S_SLOT_SCAN && !hit_q) begin
      hit_d     = 1'b1;
      hit_idx_d = pidx_q;
    end

    case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          op_d     = s_axis_tuser;
          size_d   = s_axis_tdata[15:0];
          faddr_d  = s_axis_tdata[30:16];
          addr_d   = '0;
          status_d = ST_OK;
          hit_d    = 1'b0;
          best_d   = 1'b0;
          page_d   = '0;
          last_d   = '0;
          after_d  = 1'b0;
          if (s_axis_tuser == OP_FREE) begin
            run_d   = 1'b1;
            state_d = S_FREE_SCAN;
          end else if (s_axis_tdata[15:PAGE_SHIFT] != '0) begin
            status_d = ST_TOO_LARGE;
            state_d  = S_OUT;
          end else begin
            run_d   = 1'b1;
            state_d = S_NEXT_SCAN;
          end
        end
      end
      S_FREE_SCAN: begin
        if (scan_done) state_d = S_FREE_END;
      end
      S_FREE_END: begin
        if (hit_q) begin
          cmd.clr = 1'b1;
        end else begin
          status_d = ST_BAD_FREE;
        end
        state_d = S_OUT;
      end
      S_NEXT_SCAN: begin
        if (scan_done) state_d = S_NEXT_END;
      end
      S_NEXT_END: begin
        best_d = 1'b0;
        if (!best_q) begin
          // page exhausted: move on or fall back to the bump pointer
          page_d  = page_q + PAGE_W'(1);
          last_d  = '0;
          after_d = 1'b0;
          if ({1'b0, page_q} + PAGES_W'(1) >= pages_open_q) begin
            state_d = S_BUMP;
          end else begin
            run_d   = 1'b1;
            state_d = S_NEXT_SCAN;
          end
        end else if (off_ext >= last_q && gap >= size_ext) begin
          addr_d      = {page_q, last_q[PAGE_SHIFT-1:0]};
          new_pages_d = pages_open_q;
          new_bump_d  = bump_q;
          hit_d       = 1'b0;
          run_d       = 1'b1;
          state_d     = S_SLOT_SCAN;
        end else begin
          last_d  = off_ext + {1'b0, best_len_q};
          prev_d  = best_start_q;
          after_d = 1'b1;
          run_d   = 1'b1;
          state_d = S_NEXT_SCAN;
        end
      end
      S_BUMP: begin
        nb          = bump_q;
        new_pages_d = pages_open_q;
        if (bump_sum >= {1'b0, end_pos}) begin
          nb          = end_pos;
          new_pages_d = pages_open_q + PAGES_W'(1);
        end
        if (bump_sum >= {1'b0, end_pos} && pages_open_q >= limit) begin
          status_d = ST_NO_MEM;
          state_d  = S_OUT;
        end else begin
          addr_d     = nb[ADDR_W-1:0];
          new_bump_d = nb + {{(BUMP_W-LEN_W){1'b0}}, size_q[LEN_W-1:0]};
          hit_d      = 1'b0;
          best_d     = 1'b0;
          run_d      = 1'b1;
          state_d    = S_SLOT_SCAN;
        end
      end
      S_SLOT_SCAN: begin
        if (scan_done) state_d = S_SLOT_END;
      end
      S_SLOT_END: begin
        wr_idx = hit_idx_q;
        if (!best_q && !hit_q) begin
          status_d = ST_FULL;
          addr_d   = '0;
        end else begin
          cmd.wr       = !best_q;
          pages_open_d = new_pages_q;
          bump_d       = new_bump_q;
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (m_fire) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      max_pages_q  <= MAX_PAGES_RST;
      pages_open_q <= PAGES_W'(1);
      bump_q       <= '0;
      run_q        <= 1'b0;
      idx_q        <= '0;
      pv_q         <= 1'b0;
      plast_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      pages_open_q <= pages_open_d;
      bump_q       <= bump_d;
      run_q        <= run_d;
      idx_q        <= idx_d;
      pv_q         <= pv_d;
      plast_q      <= plast_d;
      if (cfg_wr_en_i) max_pages_q <= cfg_wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    new_pages_q  <= new_pages_d;
    new_bump_q   <= new_bump_d;
    op_q         <= op_d;
    size_q       <= size_d;
    faddr_q      <= faddr_d;
    addr_q       <= addr_d;
    status_q     <= status_d;
    pidx_q       <= pidx_d;
    hit_q        <= hit_d;
    hit_idx_q    <= hit_idx_d;
    best_q       <= best_d;
    best_start_q <= best_start_d;
    best_len_q   <= best_len_d;
    page_q       <= page_d;
    last_q       <= last_d;
    prev_q       <= prev_d;
    after_q      <= after_d;
  end

  assign s_axis_tready = state_q == S_IDLE;
  assign m_axis_tvalid = state_q == S_OUT;
  assign m_axis_tdata  = {6'b0, max_pages_q, {PAGE_SHIFT{1'b0}}, bump_q,
                          status_q, (op_q == OP_ALLOC) ? addr_q : {ADDR_W{1'b0}}};

`include "paged_first_fit_allocator_assert.svh"

  `PFF_ASSERT_ALWAYS(a_one_in_flight, clk_i, rst_ni, !(s_axis_tready && m_axis_tvalid), "input and output open together")
  `PFF_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, s_fire, !s_axis_tready, "ready stays high after a transfer")
  `PFF_ASSERT_ALWAYS(a_bump_in_pages, clk_i, rst_ni, {1'b0, bump_q} < {1'b0, end_pos} || end_pos == '0, "bump position past open pages")
  `PFF_ASSERT_ALWAYS(a_status_code, clk_i, rst_ni, !m_axis_tvalid || status_q <= ST_FULL, "undefined status code")

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Paged first-fit allocator testbench
// Drives allocate and free requests with random gaps and stalls, predicts
// every result with a behavioral model of the heap and compares each result as one word.
// ----------------------------------------------------------------------------
module testbench;
  import pff_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // first member lands in the top bits, so block address goes last
  typedef struct packed {
    logic [15:0]         capacity;
    logic [BUMP_W-1:0]   used;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   addr;
  } alloc_result_t;

  class heap_scoreboard;
    logic [ADDR_W-1:0] blk_start [TABLE_DEPTH];
    logic [LEN_W-1:0]  blk_len [TABLE_DEPTH];
    bit                blk_live [TABLE_DEPTH];
    int unsigned       pages;
    int unsigned       bump;
    int unsigned       page_cap;
    alloc_result_t     pending [$];
    int                errors;

    function new();
      foreach (blk_live[i]) blk_live[i] = 0;
      pages = 1;
      bump = 0;
      page_cap = MAX_PAGES_RST;
      errors = 0;
    endfunction

    function int live_count();
      int n;
      n = 0;
      foreach (blk_live[i]) if (blk_live[i]) n++;
      return n;
    endfunction

    // Index of the live block with the smallest start on page pg, above prev when after is set; -1 when none.
    function int next_on_page(int unsigned pg, bit after, int unsigned prev);
      int best;
      best = -1;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (!blk_live[i] || blk_start[i] / PAGE_BYTES != pg) continue;
        if (after && blk_start[i] <= prev) continue;
        if (best < 0 || blk_start[i] < blk_start[best]) best = i;
      end
      return best;
    endfunction

    function void note_request(logic op, int unsigned size, int unsigned faddr);
      alloc_result_t r;
      int unsigned addr, st, new_pages, new_bump, lim, last, prev, off;
      bit found, after, dup;
      int k, slot;
      addr = 0;
      st = ST_OK;
      if (op == OP_FREE) begin
        st = ST_BAD_FREE;
        for (int i = 0; i < TABLE_DEPTH; i++)
          if (blk_live[i] && blk_start[i] == faddr) begin
            blk_live[i] = 0;
            st = ST_OK;
            break;
          end
      end else if (size >= PAGE_BYTES) begin
        st = ST_TOO_LARGE;
      end else begin
        found = 0;
        new_pages = pages;
        new_bump = bump;
        for (int unsigned p = 0; p < pages && !found; p++) begin
          last = 0;
          prev = 0;
          after = 0;
          forever begin
            k = next_on_page(p, after, prev);
            if (k < 0) break;
            off = blk_start[k] - p * PAGE_BYTES;
            if (off >= last && off - last >= size) begin
              addr = p * PAGE_BYTES + last;
              found = 1;
              break;
            end
            last = off + blk_len[k];
            prev = blk_start[k];
            after = 1;
          end
        end
        if (!found) begin
          lim = page_cap < PAGE_LIMIT ? page_cap : PAGE_LIMIT;
          if (bump + size >= pages * PAGE_BYTES) begin
            if (pages >= lim) st = ST_NO_MEM;
            else begin
              new_pages = pages + 1;
              new_bump = pages * PAGE_BYTES;
            end
          end
          if (st == ST_OK) begin
            addr = new_bump;
            new_bump += size;
          end
        end
        if (st == ST_OK) begin
          dup = 0;
          slot = -1;
          for (int i = 0; i < TABLE_DEPTH; i++)
            if (blk_live[i]) begin
              if (blk_start[i] == addr) dup = 1;
            end else if (slot < 0) slot = i;
          if (!dup && slot < 0) st = ST_FULL;
          else begin
            if (!dup) begin
              blk_start[slot] = ADDR_W'(addr);
              blk_len[slot] = LEN_W'(size);
              blk_live[slot] = 1;
            end
            pages = new_pages;
            bump = new_bump;
          end
        end
        if (st != ST_OK) addr = 0;
      end
      r.addr = ADDR_W'(addr);
      r.status = STATUS_W'(st);
      r.used = BUMP_W'(bump);
      r.capacity = 16'(page_cap * PAGE_BYTES);
      pending = {pending, r};
    endfunction

    function void check_result(alloc_result_t got);
      alloc_result_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p, actual %p", want, got);
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = OP_ALLOC;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [55:0] m_axis_tdata;
  logic        cfg_wr_en_i = 0;
  logic [3:0]  cfg_wr_data_i = '0;
  bit          sending_done = 0;

  heap_scoreboard sb = new();

  paged_first_fit_allocator dut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 120);
  endfunction

  // Valid stays high into the next request when there is no gap.
  task automatic send_request(logic op, int unsigned size, int unsigned faddr);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= op;
    s_axis_tdata <= {1'b0, faddr[14:0], size[15:0]};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_request(op, size, faddr);
  endtask

  // Drop valid, wait until every result is back, then let the block settle.
  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_max_pages(logic [3:0] v);
    drain();
    cfg_wr_en_i <= 1;
    cfg_wr_data_i <= v;
    @(posedge clk_i);
    cfg_wr_en_i <= 0;
    sb.page_cap = v;
  endtask

  function automatic int unsigned pick_live_addr();
    int unsigned idx [$];
    foreach (sb.blk_live[i]) if (sb.blk_live[i]) idx = {idx, i};
    if (idx.size() == 0) return $urandom_range(0, 32767);
    return sb.blk_start[idx[$urandom_range(0, idx.size() - 1)]];
  endfunction

  task automatic random_item();
    int r;
    int unsigned size;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      size = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 300);
      if ($urandom_range(0, 29) == 0) size = 0;
      send_request(OP_ALLOC, size, $urandom_range(0, 32767));
    end else if (r < 85) begin
      send_request(OP_FREE, $urandom_range(0, 65535), pick_live_addr());
    end else if (r < 93) begin
      send_request(OP_FREE, $urandom_range(0, 65535), $urandom_range(0, 32767));
    end else begin
      send_request(OP_ALLOC, $urandom_range(4096, 65535), $urandom_range(0, 32767));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // Directed: zero size, extremes, unknown free, duplicate start via zero size
    send_request(OP_ALLOC, 0, 0);
    send_request(OP_ALLOC, 0, 32767);
    send_request(OP_ALLOC, 65535, 0);
    send_request(OP_ALLOC, 4096, 0);
    send_request(OP_ALLOC, 4095, 0);
    send_request(OP_ALLOC, 100, 0);
    send_request(OP_FREE, 65535, 32767);
    send_request(OP_FREE, 0, 0);
    send_request(OP_ALLOC, 4095, 0);
    send_request(OP_ALLOC, 4095, 0);
    send_request(OP_ALLOC, 4095, 0);
    send_request(OP_FREE, 0, 4096);
    send_request(OP_ALLOC, 10, 0);
    send_request(OP_ALLOC, 0, 0);
    write_max_pages(4'd0);
    send_request(OP_ALLOC, 4000, 0);
    write_max_pages(4'd15);
    // Fill the table to hit the table-full case
    for (int i = 0; i < 70; i++) send_request(OP_ALLOC, $urandom_range(1, 40), 0);
    drain();
    for (int i = 0; i < 70; i++) send_request(OP_FREE, 0, pick_live_addr());
    write_max_pages(4'd1);
    for (int ph = 0; ph < 5; ph++) begin
      for (int i = 0; i < 200; i++) random_item();
      write_max_pages(ph == 4 ? 4'd8 : 4'($urandom_range(0, 15)));
    end
    drain();
    sending_done = 1;
  end

  initial begin
    alloc_result_t got;
    int stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[49:0];
        sb.check_result(got);
      end
      // hold a stall for a random length, mostly short
      if (stall > 0) begin
        stall--;
      end else if ($urandom_range(0, 3) == 0) begin
        stall = gap_len();
      end
      m_axis_tready <= (stall == 0);
    end
  end

  initial begin
    wait (sending_done);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #500ms;
    $display("Some tests failed");
    $finish;
  end
endmodule

// ===== paged_first_fit_allocator.f =====
+incdir+sv
sv/pff_pkg.sv
sv/pff_table.sv
sv/paged_first_fit_allocator.sv
dv/testbench.sv
